// File: src/lsa_pkg.sv
`default_nettype none

package lsa_pkg;

  // table geometry
  localparam int unsigned Slots = 64;
  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned LenW  = $clog2(Slots + 1);

  // request and result field widths
  localparam int unsigned ModeW = 3;
  localparam int unsigned IdW   = 6;
  localparam int unsigned AddrW = 32;
  localparam int unsigned StatW = 2;

  // all ones marks a free slot
  localparam logic [AddrW-1:0] FreeMark = '1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [LenW-1:0] len_t;

  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC = 3'd0,
    MODE_FREE  = 3'd1,
    MODE_PLACE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SCAN = 4'b0100,
    S_TRIM = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// File: src/lsa_slot_ram.sv
`default_nettype none

module lsa_slot_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read: data appears in the cycle after re_i
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/label_slot_allocator_unit.sv
`default_nettype none

// Label slot allocator: a table of 64 slots, each holding a 32-bit address,
// with all ones meaning free, plus a used length that bounds the live region.
// A request is taken when start_i is high and busy_o is low; its single
// result appears on result_id_o, slot_value_o and status_o for exactly one
// cycle with done_o high, and the receiver cannot stall it. Allocate (when
// slots remain beyond the used length), free of an inner slot or of slot
// zero, place, clear, unused modes and an out-of-range free or read answer
// in the cycle after the request and leave busy_o low, so back-to-back
// requests of these kinds run at one per cycle. A read of a live slot passes
// through S_READ, which takes the registered read data of the slot memory.
// Allocate with the used length at its maximum walks the memory for the
// lowest free slot in S_SCAN, one slot per cycle. Freeing the last live slot
// walks down over trailing free slots in S_TRIM, one per cycle. There is no
// clearing pass after reset: a valid bit per slot makes unwritten slots read
// as free, so the block takes requests right away.
module label_slot_allocator_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [lsa_pkg::ModeW-1:0] mode_i,
  input  wire logic [lsa_pkg::IdW-1:0]   label_id_i,
  input  wire logic [lsa_pkg::AddrW-1:0] address_i,
  output logic                           done_o,
  output logic      [lsa_pkg::IdW-1:0]   result_id_o,
  output logic      [lsa_pkg::AddrW-1:0] slot_value_o,
  output logic      [lsa_pkg::StatW-1:0] status_o
);
  import lsa_pkg::*;

  // control state
  state_e             state_q, state_d;
  len_t               used_q, used_d;
  idx_t               chk_q, chk_d;
  logic [Slots-1:0]   valid_q;
  logic               vld_rd_q;

  // result registers
  logic               done_q, done_d;
  logic [IdW-1:0]     rid_q, rid_d;
  logic [AddrW-1:0]   val_q, val_d;
  logic [StatW-1:0]   st_q, st_d;

  // memory ports
  logic               ram_we, ram_re, clr;
  idx_t               ram_waddr, ram_raddr;
  logic [AddrW-1:0]   ram_wdata, ram_rdata;

  logic               in_range, is_last, slot_free;
  idx_t               lbl_idx;

  lsa_slot_ram #(
    .Depth (Slots),
    .Width (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign lbl_idx   = idx_t'(label_id_i);
  assign in_range  = (len_t'(label_id_i) < used_q);
  // only meaningful when in range, so used_q is nonzero
  assign is_last   = (len_t'(label_id_i) == (used_q - len_t'(1)));
  // a slot never written since reset or clear reads as free
  assign slot_free = !vld_rd_q || (ram_rdata == FreeMark);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    chk_d     = chk_q;
    done_d    = 1'b0;
    rid_d     = rid_q;
    val_d     = val_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_waddr = lbl_idx;
    ram_wdata = FreeMark;
    ram_re    = 1'b0;
    ram_raddr = lbl_idx;
    clr       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rid_d = label_id_i;
          val_d = '0;
          st_d  = ST_OK;
          unique case (mode_i)
            MODE_ALLOC: begin
              if (used_q < len_t'(Slots)) begin
                // take the slot at the end of the live region
                ram_we    = 1'b1;
                ram_waddr = idx_t'(used_q);
                ram_wdata = '0;
                used_d    = used_q + len_t'(1);
                rid_d     = IdW'(used_q);
                done_d    = 1'b1;
              end else begin
                // start the free-slot scan at slot zero
                ram_re    = 1'b1;
                ram_raddr = '0;
                chk_d     = '0;
                state_d   = S_SCAN;
              end
            end
            MODE_FREE: begin
              if (!in_range) begin
                st_d   = ST_RANGE;
                done_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = FreeMark;
                if (is_last) begin
                  used_d = len_t'(label_id_i);
                  if (label_id_i == '0) begin
                    done_d = 1'b1;
                  end else begin
                    // look at the slot below for the trailing trim
                    ram_re    = 1'b1;
                    ram_raddr = lbl_idx - idx_t'(1);
                    state_d   = S_TRIM;
                  end
                end else begin
                  done_d = 1'b1;
                end
              end
            end
            MODE_PLACE: begin
              if (in_range) begin
                ram_we    = 1'b1;
                ram_wdata = address_i;
              end else begin
                st_d = ST_RANGE;
              end
              done_d = 1'b1;
            end
            MODE_READ: begin
              if (in_range) begin
                ram_re  = 1'b1;
                state_d = S_READ;
              end else begin
                st_d   = ST_RANGE;
                done_d = 1'b1;
              end
            end
            MODE_CLEAR: begin
              // every slot at or past the used length is already free
              clr    = 1'b1;
              used_d = '0;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        val_d   = vld_rd_q ? ram_rdata : FreeMark;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (slot_free) begin
          ram_we    = 1'b1;
          ram_waddr = chk_q;
          ram_wdata = '0;
          rid_d     = IdW'(chk_q);
          done_d    = 1'b1;
          state_d   = S_IDLE;
        end else if (chk_q == idx_t'(Slots - 1)) begin
          rid_d   = '0;
          st_d    = ST_FULL;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = chk_q + idx_t'(1);
          chk_d     = chk_q + idx_t'(1);
        end
      end
      S_TRIM: begin
        // read data is the slot just below the used length
        if (slot_free) begin
          used_d = used_q - len_t'(1);
          if (used_q == len_t'(1)) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_t'(used_q - len_t'(2));
          end
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      chk_q    <= '0;
      valid_q  <= '0;
      vld_rd_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      chk_q   <= chk_d;
      done_q  <= done_d;
      if (clr) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      // valid bit travels with the memory read data
      if (ram_re) begin
        vld_rd_q <= valid_q[ram_raddr];
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    rid_q <= rid_d;
    val_q <= val_d;
    st_q  <= st_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign result_id_o  = rid_q;
  assign slot_value_o = val_q;
  assign status_o     = st_q;

`ifndef ASSERT_OFF
  // a long operation always ends with its result strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // busy only follows an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request");

  // scan only runs with the live region at full size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (used_q == len_t'(Slots)))
    else $error("scan with slots left past the used length");

  // used length never exceeds the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= len_t'(Slots))
    else $error("used length out of range");

  // a full answer carries id zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (result_id_o == '0))
    else $error("full result with nonzero id");
`endif

endmodule

`default_nettype wire

// File: verif/label_slot_allocator_unit_tb.sv
`default_nettype none

module label_slot_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsa_pkg::*;

  // modes the block must treat as no-ops
  localparam logic [ModeW-1:0] ModeSpareLo = 3'd5;
  localparam logic [ModeW-1:0] ModeSpareHi = 3'd7;
  localparam logic [AddrW-1:0] AddrTop     = 32'hFFFF_FFFE;

  // longest answer is a full scan, so leave a margin on both
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned PhaseItems  = 533;

  typedef struct packed {
    logic [IdW-1:0]   rid;
    logic [AddrW-1:0] value;
    status_e          status;
  } answer_t;

  // one directed row, repeated reps times
  typedef struct {
    logic [ModeW-1:0] mode;
    logic [IdW-1:0]   id;
    logic [AddrW-1:0] addr;
    int unsigned      reps;
    bit               known;
    answer_t          want;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [ModeW-1:0] mode_i;
  logic [IdW-1:0]   label_id_i;
  logic [AddrW-1:0] address_i;
  logic             done_o;
  logic [IdW-1:0]   result_id_o;
  logic [AddrW-1:0] slot_value_o;
  logic [StatW-1:0] status_o;

  // shadow copy of the slot table
  logic [AddrW-1:0] slot_model [Slots];
  int               live_len;

  // answers owed by the block, oldest first
  answer_t          awaited_answers [$];
  dir_row_t         dir_rows [$];

  // directed rows may carry a hand-written answer for the request in flight
  bit               row_known;
  answer_t          row_want;

  int unsigned      idle_pct;
  int unsigned      mismatches;
  int unsigned      stall_cycles;

  label_slot_allocator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .label_id_i   (label_id_i),
    .address_i    (address_i),
    .done_o       (done_o),
    .result_id_o  (result_id_o),
    .slot_value_o (slot_value_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // apply one request to the shadow table and return the answer it owes
  function automatic answer_t next_label_answer(input logic [ModeW-1:0] mode,
                                                input logic [IdW-1:0]   id,
                                                input logic [AddrW-1:0] addr);
    answer_t ans;
    bit      found;
    ans.rid    = id;
    ans.value  = '0;
    ans.status = ST_OK;
    found      = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        if (live_len < int'(Slots)) begin
          // slots remain past the live region, take the next one
          ans.rid = IdW'(live_len);
          slot_model[live_len] = '0;
          live_len++;
        end else begin
          // region spans the table, lowest free slot wins
          for (int k = 0; k < int'(Slots); k++) begin
            if (!found && slot_model[k] == FreeMark) begin
              slot_model[k] = '0;
              ans.rid = IdW'(k);
              found = 1'b1;
            end
          end
          if (!found) begin
            ans.rid    = '0;
            ans.status = ST_FULL;
          end
        end
      end
      MODE_FREE: begin
        if (int'(id) >= live_len) begin
          ans.status = ST_RANGE;
        end else begin
          slot_model[id] = FreeMark;
          if (int'(id) == live_len - 1) begin
            // last live slot: trim every trailing free slot
            live_len--;
            while (live_len > 0 && slot_model[live_len-1] == FreeMark) live_len--;
          end
        end
      end
      MODE_PLACE: begin
        if (int'(id) < live_len) slot_model[id] = addr;
        else ans.status = ST_RANGE;
      end
      MODE_READ: begin
        if (int'(id) < live_len) ans.value = slot_model[id];
        else ans.status = ST_RANGE;
      end
      MODE_CLEAR: begin
        for (int k = 0; k < live_len; k++) slot_model[k] = FreeMark;
        live_len = 0;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  // request side: random idle cycles with junk on the fields, then hold until taken
  task automatic send_request(input logic [ModeW-1:0] mode,
                              input logic [IdW-1:0]   id,
                              input logic [AddrW-1:0] addr);
    while ($urandom_range(99, 0) < idle_pct) begin
      start_i    <= 1'b0;
      mode_i     <= ModeW'($urandom);
      label_id_i <= IdW'($urandom);
      address_i  <= $urandom;
      @(negedge clk_i);
    end
    start_i    <= 1'b1;
    mode_i     <= mode;
    label_id_i <= id;
    address_i  <= addr;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic plan(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                      input logic [AddrW-1:0] addr, input int unsigned reps);
    dir_row_t row;
    row.mode  = mode;
    row.id    = id;
    row.addr  = addr;
    row.reps  = reps;
    row.known = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endtask

  task automatic plan_known(input logic [ModeW-1:0] mode, input logic [IdW-1:0] id,
                            input logic [AddrW-1:0] addr, input logic [IdW-1:0] rid,
                            input logic [AddrW-1:0] value, input status_e status);
    dir_row_t row;
    row.mode        = mode;
    row.id          = id;
    row.addr        = addr;
    row.reps        = 1;
    row.known       = 1'b1;
    row.want.rid    = rid;
    row.want.value  = value;
    row.want.status = status;
    dir_rows.push_back(row);
  endtask

  function automatic logic [IdW-1:0] pick_id();
    int unsigned r;
    r = $urandom_range(9, 0);
    // mostly live ids, often the last one to provoke trims
    if (live_len > 0 && r < 6) return IdW'($urandom_range(live_len - 1, 0));
    if (live_len > 0 && r < 8) return IdW'(live_len - 1);
    return IdW'($urandom);
  endfunction

  function automatic logic [AddrW-1:0] pick_address();
    logic [AddrW-1:0] a;
    case ($urandom_range(9, 0))
      0:       a = '0;
      1:       a = AddrTop;
      default: a = $urandom;
    endcase
    // all ones lies outside the address range
    if (a == FreeMark) a = AddrTop;
    return a;
  endfunction

  // random traffic in episodes: each episode leans toward filling or draining
  task automatic run_random(input int unsigned items);
    int unsigned      sent;
    int unsigned      alloc_permille;
    int unsigned      ep_len;
    int unsigned      pick;
    logic [ModeW-1:0] mode;
    sent = 0;
    while (sent < items) begin
      alloc_permille = $urandom_range(700, 250);
      ep_len         = $urandom_range(220, 40);
      for (int j = 0; j < int'(ep_len) && sent < items; j++) begin
        if ($urandom_range(999, 0) < alloc_permille) begin
          mode = MODE_ALLOC;
        end else begin
          pick = $urandom_range(99, 0);
          if (pick < 40)      mode = MODE_FREE;
          else if (pick < 68) mode = MODE_PLACE;
          else if (pick < 96) mode = MODE_READ;
          else if (pick < 99) mode = ModeW'($urandom_range(ModeSpareHi, ModeSpareLo));
          else                mode = MODE_CLEAR;
        end
        send_request(mode, pick_id(), pick_address());
        sent++;
      end
      // wipe between some episodes so short tables are revisited
      if ($urandom_range(2, 0) == 0) begin
        send_request(MODE_CLEAR, IdW'($urandom), pick_address());
        sent++;
      end
    end
  endtask

  // result side: sample at the rising edge, predict on every accepted request
  always @(posedge clk_i) begin : result_check
    answer_t want;
    answer_t got;
    bit      taken;
    if (rst_ni) begin
      taken = (start_i === 1'b1) && (busy_o === 1'b0);

      // a result never shares the edge of the request that caused it
      if (done_o === 1'b1) begin
        if (awaited_answers.size() == 0) begin
          $error("result with no request pending: id %0d value %h status %0d",
                 result_id_o, slot_value_o, status_o);
          mismatches++;
        end else begin
          want       = awaited_answers.pop_front();
          got.rid    = result_id_o;
          got.value  = slot_value_o;
          got.status = status_e'(status_o);
          if (got.rid !== want.rid) begin
            $error("result_id: expected %0d, got %0d", want.rid, got.rid);
            mismatches++;
          end
          if (got.value !== want.value) begin
            $error("slot_value: expected %h, got %h", want.value, got.value);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
        end
      end

      if (taken) begin
        want = next_label_answer(mode_i, label_id_i, address_i);
        // hand-written rows override the prediction, state still advances
        awaited_answers.push_back(row_known ? row_want : want);
      end

      // watchdog on handshake progress
      if (taken || done_o === 1'b1) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no request or result for %0d cycles", StallLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    mode_i       = '0;
    label_id_i   = '0;
    address_i    = '0;
    row_known    = 1'b0;
    row_want     = '0;
    mismatches   = 0;
    stall_cycles = 0;
    idle_pct     = 28;
    live_len     = 0;
    for (int k = 0; k < int'(Slots); k++) slot_model[k] = FreeMark;

    // empty table: every id is out of range
    plan_known(MODE_READ,  6'd0,  '0,           6'd0,  '0, ST_RANGE);
    plan_known(MODE_FREE,  6'd63, '0,           6'd63, '0, ST_RANGE);
    plan_known(MODE_PLACE, 6'd0,  32'h1234,     6'd0,  '0, ST_RANGE);
    // allocate from the end ignores the id and zeroes the slot
    plan_known(MODE_ALLOC, 6'd21, '0,           6'd0,  '0, ST_OK);
    plan_known(MODE_ALLOC, 6'd0,  '0,           6'd1,  '0, ST_OK);
    plan_known(MODE_PLACE, 6'd1,  AddrTop,      6'd1,  '0, ST_OK);
    plan_known(MODE_READ,  6'd1,  '0,           6'd1,  AddrTop, ST_OK);
    plan_known(MODE_READ,  6'd0,  '0,           6'd0,  '0, ST_OK);
    // placing all ones turns the slot free
    plan_known(MODE_PLACE, 6'd0,  FreeMark,     6'd0,  '0, ST_OK);
    plan_known(MODE_READ,  6'd0,  '0,           6'd0,  FreeMark, ST_OK);
    // freeing the last slot trims the free slot below as well
    plan_known(MODE_FREE,  6'd1,  '0,           6'd1,  '0, ST_OK);
    plan_known(MODE_READ,  6'd0,  '0,           6'd0,  '0, ST_RANGE);
    // unused modes echo the id and change nothing
    plan_known(ModeSpareLo,         6'd42, '0,           6'd42, '0, ST_OK);
    plan_known(ModeSpareLo + 3'd1,  6'd0,  AddrTop,      6'd0,  '0, ST_OK);
    plan_known(ModeSpareHi,         6'd63, 32'h5555AAAA, 6'd63, '0, ST_OK);
    // fill the whole table, then hit the full case
    plan(MODE_ALLOC, 6'd0, '0, Slots);
    plan_known(MODE_ALLOC, 6'd9,  '0,           6'd0,  '0, ST_FULL);
    plan_known(MODE_READ,  6'd63, '0,           6'd63, '0, ST_OK);
    plan(MODE_PLACE, 6'd63, 32'h8000_0001, 1);
    // inner frees, then the scan must return the lowest free slot first
    plan_known(MODE_FREE,  6'd37, '0,           6'd37, '0, ST_OK);
    plan(MODE_FREE, 6'd5, '0, 1);
    plan(MODE_FREE, 6'd0, '0, 1);
    plan_known(MODE_ALLOC, 6'd0,  '0,           6'd0,  '0, ST_OK);
    plan(MODE_ALLOC, 6'd0, '0, 2);
    // free the top two, the trim stops at the used slot below
    plan(MODE_FREE,  6'd62, '0, 1);
    plan(MODE_FREE,  6'd63, '0, 1);
    plan(MODE_ALLOC, 6'd0,  '0, 1);
    plan_known(MODE_CLEAR, 6'd63, AddrTop,      6'd63, '0, ST_OK);
    plan_known(MODE_READ,  6'd0,  '0,           6'd0,  '0, ST_RANGE);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      row_known = dir_rows[r].known;
      row_want  = dir_rows[r].want;
      repeat (dir_rows[r].reps) send_request(dir_rows[r].mode, dir_rows[r].id,
                                             dir_rows[r].addr);
    end
    row_known = 1'b0;

    // light sender gaps, heavy sender gaps, then back to back
    idle_pct = 28;
    run_random(PhaseItems);
    idle_pct = 63;
    run_random(PhaseItems);
    idle_pct = 0;
    run_random(PhaseItems);
    start_i <= 1'b0;

    // let outstanding answers land, then watch for strays
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
